### rtl/i2cms_pkg.sv
// Package for the I2C master byte sequencer.
// Holds the phase, mode, status, action and link codes, the register indexes and the result item type.
// No dependencies.
`default_nettype none

package i2cms_pkg;

    // Sequencer phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_ADDRESS  = 3'd1;
    localparam logic [2:0] PH_TRANSMIT = 3'd2;
    localparam logic [2:0] PH_RECEIVE  = 3'd3;
    localparam logic [2:0] PH_ERROR    = 3'd4;

    // Input item kinds
    localparam logic [2:0] MODE_WRITE  = 3'd0;
    localparam logic [2:0] MODE_READ   = 3'd1;
    localparam logic [2:0] MODE_STATUS = 3'd2;
    localparam logic [2:0] MODE_TMO    = 3'd3;
    localparam logic [2:0] MODE_REPEAT = 3'd4;

    // Engine status codes
    localparam logic [3:0] ST_START     = 4'd0;
    localparam logic [3:0] ST_RESTART   = 4'd1;
    localparam logic [3:0] ST_ADDRW_ACK = 4'd2;
    localparam logic [3:0] ST_ADDRR_ACK = 4'd3;
    localparam logic [3:0] ST_TX_ACK    = 4'd4;
    localparam logic [3:0] ST_RX_ACK    = 4'd5;
    localparam logic [3:0] ST_RX_NACK   = 4'd6;
    localparam logic [3:0] ST_BUS_ERR   = 4'd7;
    localparam logic [3:0] ST_ARB_LOST  = 4'd8;
    localparam logic [3:0] ST_TX_NACK   = 4'd9;
    localparam logic [3:0] ST_ADDRW_NAK = 4'd10;
    localparam logic [3:0] ST_ADDRR_NAK = 4'd11;
    localparam logic [3:0] ST_RELEASED  = 4'd12;
    localparam logic [3:0] ST_OTHER     = 4'd13;

    // Action codes
    localparam logic [1:0] START_LEAVE    = 2'd0;
    localparam logic [1:0] START_REQUEST  = 2'd1;
    localparam logic [1:0] START_WITHDRAW = 2'd2;

    localparam logic [1:0] ACK_LEAVE = 2'd0;
    localparam logic [1:0] ACK_ACK   = 2'd1;
    localparam logic [1:0] ACK_NACK  = 2'd2;

    localparam logic [1:0] TMO_LEAVE  = 2'd0;
    localparam logic [1:0] TMO_ARM    = 2'd1;
    localparam logic [1:0] TMO_DISARM = 2'd2;

    localparam logic [1:0] LINK_IDLE  = 2'd0;
    localparam logic [1:0] LINK_BUSY  = 2'd1;
    localparam logic [1:0] LINK_ERROR = 2'd2;

    // Register indexes (address bit 2)
    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_TEN    = 1'b1;

    typedef struct packed {
        logic        write_data;
        logic [10:0] data_word;
        logic [1:0]  start_action;
        logic        stop_request;
        logic [1:0]  ack_control;
        logic        clear_interrupt;
        logic        read_valid;
        logic [7:0]  read_byte;
        logic        done_event;
        logic [1:0]  link_status;
        logic [1:0]  timeout_action;
    } result_t;

endpackage

`default_nettype wire

### rtl/i2cms_step.sv
// Next-state and action logic of the I2C master byte sequencer for one item.
// Purely combinational; uses i2cms_pkg.
`default_nettype none

module i2cms_step #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic [2:0]             mode,
    input  wire logic [15:0]            transfer_length,
    input  wire logic [3:0]             status_code,
    input  wire logic [7:0]             tx_byte,
    input  wire logic [7:0]             rx_data,
    input  wire logic [9:0]             target_address,
    input  wire logic [2:0]             phase,
    input  wire logic [LENGTH_BITS-1:0] send_left,
    input  wire logic [LENGTH_BITS-1:0] receive_left,
    input  wire logic                   repeat_pending,
    input  wire logic [3:0]             previous_status,
    output logic [2:0]                  phase_next,
    output logic [LENGTH_BITS-1:0]      send_left_next,
    output logic [LENGTH_BITS-1:0]      receive_left_next,
    output logic                        repeat_pending_next,
    output logic [3:0]                  previous_status_next,
    output i2cms_pkg::result_t          result
);

    // Counts saturate at the smaller of the counter range and 16 bits
    localparam longint CNT_MAX = (LENGTH_BITS >= 16) ? 64'd65535
                                                     : ((64'd1 << LENGTH_BITS) - 64'd1);
    localparam logic [32:0] CNT_MAX_W = 33'(CNT_MAX);
    localparam logic [LENGTH_BITS-1:0] CNT_ONE = LENGTH_BITS'(1);

    logic [32:0]            len_wide;
    logic [32:0]            len_sat;
    logic [LENGTH_BITS-1:0] len_cnt;
    logic [3:0]             st;
    logic                   handled;
    logic [LENGTH_BITS-1:0] send_dec;
    logic [LENGTH_BITS-1:0] recv_dec;

    assign len_wide = {17'd0, transfer_length};
    assign len_sat  = (len_wide > CNT_MAX_W) ? CNT_MAX_W : len_wide;
    assign len_cnt  = len_sat[LENGTH_BITS-1:0];
    assign st       = (status_code > i2cms_pkg::ST_OTHER) ? i2cms_pkg::ST_OTHER : status_code;
    assign send_dec = (send_left == '0) ? '0 : send_left - CNT_ONE;
    assign recv_dec = (receive_left == '0) ? '0 : receive_left - CNT_ONE;

    always_comb
    begin
        phase_next           = phase;
        send_left_next       = send_left;
        receive_left_next    = receive_left;
        repeat_pending_next  = repeat_pending;
        previous_status_next = previous_status;
        result               = '0;
        handled              = 1'b0;

        case (mode)
            i2cms_pkg::MODE_WRITE, i2cms_pkg::MODE_READ:
            begin
                if (transfer_length != 16'd0)
                begin
                    if (mode == i2cms_pkg::MODE_WRITE)
                    begin
                        send_left_next    = len_cnt;
                        receive_left_next = '0;
                    end
                    else
                    begin
                        send_left_next    = '0;
                        receive_left_next = len_cnt;
                        // engine parked after txAck continues with a repeated start
                        if (previous_status == i2cms_pkg::ST_TX_ACK)
                            result.clear_interrupt = 1'b1;
                    end
                    phase_next            = i2cms_pkg::PH_ADDRESS;
                    result.start_action   = i2cms_pkg::START_REQUEST;
                    result.timeout_action = i2cms_pkg::TMO_ARM;
                end
            end
            i2cms_pkg::MODE_REPEAT:
            begin
                repeat_pending_next = 1'b1;
            end
            i2cms_pkg::MODE_TMO:
            begin
                phase_next           = i2cms_pkg::PH_ERROR;
                result.done_event    = 1'b1;
                previous_status_next = i2cms_pkg::ST_RELEASED;
                handled              = 1'b1;
            end
            i2cms_pkg::MODE_STATUS:
            begin
                previous_status_next   = st;
                handled                = 1'b1;
                result.clear_interrupt = 1'b1;
                case (st)
                    i2cms_pkg::ST_START, i2cms_pkg::ST_RESTART:
                    begin
                        if (phase == i2cms_pkg::PH_ADDRESS)
                        begin
                            result.write_data = 1'b1;
                            result.data_word  = {target_address, (send_left == '0)};
                        end
                        result.start_action = i2cms_pkg::START_WITHDRAW;
                    end
                    i2cms_pkg::ST_ADDRW_ACK:
                    begin
                        result.write_data = 1'b1;
                        result.data_word  = {3'd0, tx_byte};
                        send_left_next    = send_dec;
                        phase_next        = i2cms_pkg::PH_TRANSMIT;
                    end
                    i2cms_pkg::ST_ADDRR_ACK:
                    begin
                        result.ack_control = (receive_left > CNT_ONE) ? i2cms_pkg::ACK_ACK
                                                                      : i2cms_pkg::ACK_NACK;
                        phase_next = i2cms_pkg::PH_RECEIVE;
                    end
                    i2cms_pkg::ST_TX_ACK:
                    begin
                        if (phase == i2cms_pkg::PH_TRANSMIT)
                        begin
                            if (send_left != '0)
                            begin
                                result.write_data = 1'b1;
                                result.data_word  = {3'd0, tx_byte};
                                send_left_next    = send_dec;
                            end
                            else
                            begin
                                // repeated start: leave the flag set, no stop
                                if (repeat_pending)
                                begin
                                    repeat_pending_next    = 1'b0;
                                    result.clear_interrupt = 1'b0;
                                end
                                else
                                begin
                                    result.stop_request = 1'b1;
                                end
                                phase_next        = i2cms_pkg::PH_IDLE;
                                result.done_event = 1'b1;
                            end
                        end
                    end
                    i2cms_pkg::ST_RX_ACK:
                    begin
                        result.read_valid  = 1'b1;
                        result.read_byte   = rx_data;
                        receive_left_next  = recv_dec;
                        result.ack_control = (recv_dec > CNT_ONE) ? i2cms_pkg::ACK_ACK
                                                                  : i2cms_pkg::ACK_NACK;
                    end
                    i2cms_pkg::ST_RX_NACK:
                    begin
                        if (phase == i2cms_pkg::PH_RECEIVE)
                        begin
                            result.read_valid   = 1'b1;
                            result.read_byte    = rx_data;
                            receive_left_next   = recv_dec;
                            result.stop_request = 1'b1;
                            phase_next          = i2cms_pkg::PH_IDLE;
                            result.done_event   = 1'b1;
                        end
                    end
                    i2cms_pkg::ST_BUS_ERR, i2cms_pkg::ST_ARB_LOST, i2cms_pkg::ST_TX_NACK,
                    i2cms_pkg::ST_ADDRW_NAK, i2cms_pkg::ST_ADDRR_NAK:
                    begin
                        result.stop_request = 1'b1;
                        repeat_pending_next = 1'b0;
                        phase_next          = i2cms_pkg::PH_ERROR;
                        result.done_event   = 1'b1;
                    end
                    i2cms_pkg::ST_RELEASED:
                    begin
                        result.clear_interrupt = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        if (handled && (phase_next == i2cms_pkg::PH_IDLE || phase_next == i2cms_pkg::PH_ERROR))
            result.timeout_action = i2cms_pkg::TMO_DISARM;

        if (phase_next == i2cms_pkg::PH_ERROR)
            result.link_status = i2cms_pkg::LINK_ERROR;
        else if (phase_next == i2cms_pkg::PH_IDLE)
            result.link_status = i2cms_pkg::LINK_IDLE;
        else
            result.link_status = i2cms_pkg::LINK_BUSY;
    end

endmodule

`default_nettype wire

### rtl/i2c_master_byte_sequencer.sv
// I2C master byte sequencer, top level: input register, state, output buffer, APB registers.
// Depends on i2cms_pkg and i2cms_step.
//
// The block takes one item per clock while in_stall is low and returns exactly one
// result item for each. An accepted item is held in the input register; the step
// logic then decides the engine actions and the next sequencer state, and the result
// lands in a two-entry output buffer (output register plus skid). A result passes the
// input register, then the output register, or the skid entry while the output
// register holds an untaken result. The sustained rate is one item per cycle while
// out_stall is low, as the step logic is combinational. in_stall rises only while the
// skid entry is occupied, so input keeps flowing while one result waits to be taken.
// Registers: target_address at byte 0x0, ten_bit_mode at byte 0x4; writes should
// happen only while the block is idle. ten_bit_mode is stored and read back but does
// not change any result. LENGTH_BITS sets the width of the byte counters; start
// lengths saturate at the smaller of 65535 and the counter maximum.
`default_nettype none

module i2c_master_byte_sequencer #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // item input
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  mode,
    input  wire logic [15:0] transfer_length,
    input  wire logic [3:0]  status_code,
    input  wire logic [7:0]  tx_byte,
    input  wire logic [7:0]  rx_data,

    // result output
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             write_data,
    output logic [10:0]      data_word,
    output logic [1:0]       start_action,
    output logic             stop_request,
    output logic [1:0]       ack_control,
    output logic             clear_interrupt,
    output logic             read_valid,
    output logic [7:0]       read_byte,
    output logic             done_event,
    output logic [1:0]       link_status,
    output logic [1:0]       timeout_action,

    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration registers
    logic [9:0] target_address_reg;
    logic       ten_bit_mode_reg;
    logic       cfg_write;

    // input register
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [2:0]  mode_reg;
    logic [15:0] transfer_length_reg;
    logic [3:0]  status_code_reg;
    logic [7:0]  tx_byte_reg;
    logic [7:0]  rx_data_reg;
    logic        in_take;

    // sequencer state
    logic [2:0]             phase_reg;
    logic [2:0]             phase_next;
    logic [LENGTH_BITS-1:0] send_left_reg;
    logic [LENGTH_BITS-1:0] send_left_next;
    logic [LENGTH_BITS-1:0] receive_left_reg;
    logic [LENGTH_BITS-1:0] receive_left_next;
    logic                   repeat_pending_reg;
    logic                   repeat_pending_next;
    logic [3:0]             previous_status_reg;
    logic [3:0]             previous_status_next;

    // output buffer
    i2cms_pkg::result_t step_res;
    i2cms_pkg::result_t out_res_reg;
    i2cms_pkg::result_t skid_res_reg;
    logic               out_valid_reg;
    logic               skid_valid_reg;
    logic               advance;
    logic               out_take;

    // --------------------------------------------------------------------
    // APB: always ready, write on the access phase
    // --------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_address_reg <= '0;
            ten_bit_mode_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == i2cms_pkg::REG_TARGET)
                target_address_reg <= pwdata[9:0];
            else
                ten_bit_mode_reg <= pwdata[0];
        end
    end

    // paddr[1:0] is the byte offset within a word and is not decoded
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == i2cms_pkg::REG_TARGET)
            prdata = {22'd0, target_address_reg};
        else
            prdata = {31'd0, ten_bit_mode_reg};
    end

    // --------------------------------------------------------------------
    // Item flow: the held item moves on whenever the skid entry is free
    // --------------------------------------------------------------------
    assign advance       = in_valid_reg && !skid_valid_reg;
    assign in_stall      = in_valid_reg && skid_valid_reg;
    assign in_take       = in_valid && !in_stall;
    assign in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_take      = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg            <= mode;
            transfer_length_reg <= transfer_length;
            status_code_reg     <= status_code;
            tx_byte_reg         <= tx_byte;
            rx_data_reg         <= rx_data;
        end
    end

    // --------------------------------------------------------------------
    // Step logic and sequencer state
    // --------------------------------------------------------------------
    i2cms_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .mode                 (mode_reg),
        .transfer_length      (transfer_length_reg),
        .status_code          (status_code_reg),
        .tx_byte              (tx_byte_reg),
        .rx_data              (rx_data_reg),
        .target_address       (target_address_reg),
        .phase                (phase_reg),
        .send_left            (send_left_reg),
        .receive_left         (receive_left_reg),
        .repeat_pending       (repeat_pending_reg),
        .previous_status      (previous_status_reg),
        .phase_next           (phase_next),
        .send_left_next       (send_left_next),
        .receive_left_next    (receive_left_next),
        .repeat_pending_next  (repeat_pending_next),
        .previous_status_next (previous_status_next),
        .result               (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= i2cms_pkg::PH_IDLE;
            send_left_reg       <= '0;
            receive_left_reg    <= '0;
            repeat_pending_reg  <= 1'b0;
            previous_status_reg <= i2cms_pkg::ST_OTHER;
        end
        else if (advance)
        begin
            phase_reg           <= phase_next;
            send_left_reg       <= send_left_next;
            receive_left_reg    <= receive_left_next;
            repeat_pending_reg  <= repeat_pending_next;
            previous_status_reg <= previous_status_next;
        end
    end

    // --------------------------------------------------------------------
    // Output register plus skid entry
    // --------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_take || !out_valid_reg)
            begin
                // output slot frees: skid first, else the new result
                out_valid_reg  <= skid_valid_reg || advance;
                skid_valid_reg <= 1'b0;
            end
            else if (advance)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_res_reg <= skid_res_reg;
            else if (advance)
                out_res_reg <= step_res;
        end
        else if (advance)
        begin
            skid_res_reg <= step_res;
        end
    end

    assign out_valid       = out_valid_reg;
    assign write_data      = out_res_reg.write_data;
    assign data_word       = out_res_reg.data_word;
    assign start_action    = out_res_reg.start_action;
    assign stop_request    = out_res_reg.stop_request;
    assign ack_control     = out_res_reg.ack_control;
    assign clear_interrupt = out_res_reg.clear_interrupt;
    assign read_valid      = out_res_reg.read_valid;
    assign read_byte       = out_res_reg.read_byte;
    assign done_event      = out_res_reg.done_event;
    assign link_status     = out_res_reg.link_status;
    assign timeout_action  = out_res_reg.timeout_action;

endmodule

`default_nettype wire

### tb/sv/i2c_master_byte_sequencer_tb.sv
// Self-checking testbench for the I2C master byte sequencer.
// Directed item table, then random transfers checked against an in-bench predictor.
// Depends on i2cms_pkg and the i2c_master_byte_sequencer RTL.
`timescale 1ns / 1ps

module i2c_master_byte_sequencer_tb;
    import i2cms_pkg::*;

    // An item kind the block ignores, and a status code past the defined range
    localparam logic [2:0] MODE_IGNORED = 3'd5;
    localparam logic [3:0] ST_UNDEFINED = 4'd15;

    // Byte addresses of the two registers (index in address bit 2)
    localparam logic [2:0] ADDR_TARGET = {REG_TARGET, 2'b00};
    localparam logic [2:0] ADDR_TEN    = {REG_TEN, 2'b00};

    typedef struct {
        logic [2:0]  m;
        logic [15:0] len;
        logic [3:0]  st;
        logic [7:0]  txb;
        logic [7:0]  rxb;
        bit          typed;
        result_t     want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  mode;
    logic [15:0] transfer_length;
    logic [3:0]  status_code;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_data;
    logic        out_valid;
    logic        out_stall;
    logic        write_data;
    logic [10:0] data_word;
    logic [1:0]  start_action;
    logic        stop_request;
    logic [1:0]  ack_control;
    logic        clear_interrupt;
    logic        read_valid;
    logic [7:0]  read_byte;
    logic        done_event;
    logic [1:0]  link_status;
    logic [1:0]  timeout_action;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the sequencer state and registers
    logic [2:0]  seq_phase        = PH_IDLE;
    logic [15:0] bytes_to_send    = '0;
    logic [15:0] bytes_to_receive = '0;
    bit          restart_armed    = 1'b0;
    logic [3:0]  last_status      = ST_OTHER;
    logic [9:0]  cfg_target       = '0;
    logic        cfg_ten_bit      = 1'b0;

    result_t     expected_results[$];
    stim_row_t   directed_rows[$];

    // Typed expectation for the item currently on the input port
    bit          cur_typed = 1'b0;
    result_t     cur_want  = '0;

    int unsigned send_idle_pct = 31;
    int unsigned stall_pct     = 81;
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned reg_writes      = 0;
    int unsigned mismatch_count  = 0;

    i2c_master_byte_sequencer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .transfer_length (transfer_length),
        .status_code     (status_code),
        .tx_byte         (tx_byte),
        .rx_data         (rx_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .write_data      (write_data),
        .data_word       (data_word),
        .start_action    (start_action),
        .stop_request    (stop_request),
        .ack_control     (ack_control),
        .clear_interrupt (clear_interrupt),
        .read_valid      (read_valid),
        .read_byte       (read_byte),
        .done_event      (done_event),
        .link_status     (link_status),
        .timeout_action  (timeout_action),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #2_000_000;
        $display("i2c_master_byte_sequencer regression: fail");
        $finish;
    end

    // Random backpressure on the result side, changed at the falling edge
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Builds one result item from its fields, for typed table rows
    function automatic result_t outcome(input logic wr, input logic [10:0] word,
                                        input logic [1:0] start, input logic stop,
                                        input logic [1:0] ack, input logic clr,
                                        input logic rv, input logic [7:0] rb,
                                        input logic done, input logic [1:0] link,
                                        input logic [1:0] tmo);
        result_t r;
        r = {wr, word, start, stop, ack, clr, rv, rb, done, link, tmo};
        return r;
    endfunction

    // Next-state and action logic of the sequencer for one accepted item.
    // Lengths are 16 bits wide, so the 65535 saturation never bites here.
    function automatic result_t sequencer_step(input logic [2:0] m, input logic [15:0] len,
                                               input logic [3:0] st, input logic [7:0] txb,
                                               input logic [7:0] rxb);
        result_t    r;
        logic [3:0] code;
        bit         handled;
        r       = '0;
        handled = 1'b0;
        if ((m == MODE_WRITE || m == MODE_READ) && len != 0)
        begin
            if (m == MODE_WRITE)
            begin
                bytes_to_send    = len;
                bytes_to_receive = '0;
            end
            else
            begin
                bytes_to_send    = '0;
                bytes_to_receive = len;
                // read right after a write's last ack: let the engine restart
                if (last_status == ST_TX_ACK)
                    r.clear_interrupt = 1'b1;
            end
            seq_phase        = PH_ADDRESS;
            r.start_action   = START_REQUEST;
            r.timeout_action = TMO_ARM;
        end
        else if (m == MODE_REPEAT)
        begin
            restart_armed = 1'b1;
        end
        else if (m == MODE_TMO)
        begin
            // treated as a bus release: no interrupt clear
            seq_phase    = PH_ERROR;
            r.done_event = 1'b1;
            last_status  = ST_RELEASED;
            handled      = 1'b1;
        end
        else if (m == MODE_STATUS)
        begin
            code              = (st > ST_OTHER) ? ST_OTHER : st;
            last_status       = code;
            handled           = 1'b1;
            r.clear_interrupt = 1'b1;
            case (code)
                ST_START, ST_RESTART:
                begin
                    if (seq_phase == PH_ADDRESS)
                    begin
                        r.write_data = 1'b1;
                        r.data_word  = {cfg_target, bytes_to_send == 16'd0};
                    end
                    r.start_action = START_WITHDRAW;
                end
                ST_ADDRW_ACK:
                begin
                    r.write_data  = 1'b1;
                    r.data_word   = {3'b000, txb};
                    bytes_to_send = (bytes_to_send != 16'd0) ? bytes_to_send - 16'd1 : 16'd0;
                    seq_phase     = PH_TRANSMIT;
                end
                ST_ADDRR_ACK:
                begin
                    r.ack_control = (bytes_to_receive > 16'd1) ? ACK_ACK : ACK_NACK;
                    seq_phase     = PH_RECEIVE;
                end
                ST_TX_ACK:
                begin
                    if (seq_phase == PH_TRANSMIT)
                    begin
                        if (bytes_to_send != 16'd0)
                        begin
                            r.write_data  = 1'b1;
                            r.data_word   = {3'b000, txb};
                            bytes_to_send = bytes_to_send - 16'd1;
                        end
                        else
                        begin
                            // last byte out: repeated start holds the bus, else stop
                            if (restart_armed)
                            begin
                                restart_armed     = 1'b0;
                                r.clear_interrupt = 1'b0;
                            end
                            else
                                r.stop_request = 1'b1;
                            seq_phase    = PH_IDLE;
                            r.done_event = 1'b1;
                        end
                    end
                end
                ST_RX_ACK:
                begin
                    r.read_valid     = 1'b1;
                    r.read_byte      = rxb;
                    bytes_to_receive = (bytes_to_receive != 16'd0) ? bytes_to_receive - 16'd1
                                                                   : 16'd0;
                    r.ack_control    = (bytes_to_receive > 16'd1) ? ACK_ACK : ACK_NACK;
                end
                ST_RX_NACK:
                begin
                    if (seq_phase == PH_RECEIVE)
                    begin
                        r.read_valid     = 1'b1;
                        r.read_byte      = rxb;
                        bytes_to_receive = (bytes_to_receive != 16'd0)
                                           ? bytes_to_receive - 16'd1 : 16'd0;
                        r.stop_request   = 1'b1;
                        seq_phase        = PH_IDLE;
                        r.done_event     = 1'b1;
                    end
                end
                ST_BUS_ERR, ST_ARB_LOST, ST_TX_NACK, ST_ADDRW_NAK, ST_ADDRR_NAK:
                begin
                    r.stop_request = 1'b1;
                    restart_armed  = 1'b0;
                    seq_phase      = PH_ERROR;
                    r.done_event   = 1'b1;
                end
                ST_RELEASED:
                    r.clear_interrupt = 1'b0;
                default:
                    ;
            endcase
        end
        if (handled && (seq_phase == PH_IDLE || seq_phase == PH_ERROR))
            r.timeout_action = TMO_DISARM;
        r.link_status = (seq_phase == PH_ERROR) ? LINK_ERROR :
                        (seq_phase == PH_IDLE) ? LINK_IDLE : LINK_BUSY;
        return r;
    endfunction

    // Four-state compare, so an unknown output bit counts as a mismatch
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Prediction on input acceptance, comparison on result acceptance
    always @(posedge clk)
    begin : scoreboard
        result_t pred;
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                pred = sequencer_step(mode, transfer_length, status_code, tx_byte, rx_data);
                expected_results.push_back(cur_typed ? cur_want : pred);
            end
            if (out_valid && !out_stall)
            begin
                got = {write_data, data_word, start_action, stop_request, ack_control,
                       clear_interrupt, read_valid, read_byte, done_event, link_status,
                       timeout_action};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result item, expected none, actual %0h",
                             $time, got);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    check_field("write_data", want.write_data, got.write_data);
                    check_field("data_word", want.data_word, got.data_word);
                    check_field("start_action", want.start_action, got.start_action);
                    check_field("stop_request", want.stop_request, got.stop_request);
                    check_field("ack_control", want.ack_control, got.ack_control);
                    check_field("clear_interrupt", want.clear_interrupt, got.clear_interrupt);
                    check_field("read_valid", want.read_valid, got.read_valid);
                    check_field("read_byte", want.read_byte, got.read_byte);
                    check_field("done_event", want.done_event, got.done_event);
                    check_field("link_status", want.link_status, got.link_status);
                    check_field("timeout_action", want.timeout_action, got.timeout_action);
                end
            end
        end
    end

    // Presents one item after a random gap and holds it until accepted.
    // Valid stays high after acceptance; the next call replaces the item or lowers valid, and settle() lowers it.
    task automatic push_item(input logic [2:0] m, input logic [15:0] len,
                             input logic [3:0] st, input logic [7:0] txb,
                             input logic [7:0] rxb, input bit typed, input result_t want);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        mode            <= m;
        transfer_length <= len;
        status_code     <= st;
        tx_byte         <= txb;
        rx_data         <= rxb;
        cur_typed        = typed;
        cur_want         = want;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        if (m <= MODE_REPEAT)
            items_sent++;
    endtask

    task automatic send_status(input logic [3:0] code);
        push_item(MODE_STATUS, $urandom, code, $urandom, $urandom, 1'b0, '0);
    endtask

    // Drops valid and waits until every expected result has been taken
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // APB write (setup + access), then read back the stored bits
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] want;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_TEN)
            cfg_ten_bit = value[0];
        else
            cfg_target = value[9:0];
        reg_writes++;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        want = (addr == ADDR_TEN) ? {31'b0, cfg_ten_bit} : {22'b0, cfg_target};
        if ((prdata & ((addr == ADDR_TEN) ? 32'h1 : 32'h3FF)) != want)
        begin
            $display("%0t: register %0h readback mismatch, expected %0h, actual %0h",
                     $time, addr, want, prdata);
            mismatch_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One bus transfer: start, address, data bytes, last ack or nack. Some are cut short
    // by a bus fault, a timeout or a stray status; long lengths are always cut.
    task automatic run_transfer();
        int unsigned n;
        int unsigned steps;
        int unsigned fault_at;
        int unsigned k;
        int unsigned pick;
        bit          is_read;
        logic [3:0]  code;
        is_read  = $urandom_range(1);
        n        = ($urandom_range(15) == 0) ? $urandom_range(65535) : $urandom_range(1, 4);
        steps    = (n > 5) ? 5 : n;
        fault_at = ($urandom_range(4) == 0 || n > 5) ? $urandom_range(steps + 1) : 99;
        if (!is_read && $urandom_range(2) == 0)
            push_item(MODE_REPEAT, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
        push_item(is_read ? MODE_READ : MODE_WRITE, n[15:0], $urandom, $urandom, $urandom,
                  1'b0, '0);
        for (k = 0; k <= steps + 1; k++)
        begin
            if (k == fault_at)
            begin
                pick = $urandom_range(3);
                if (pick == 0)
                    push_item(MODE_TMO, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
                else if (pick == 3)
                    send_status(4'($urandom_range(ST_RELEASED, ST_UNDEFINED)));
                else
                    send_status(4'($urandom_range(ST_BUS_ERR, ST_ADDRR_NAK)));
                return;
            end
            if (k == 0)
                code = $urandom_range(1) ? ST_RESTART : ST_START;
            else if (k == 1)
                code = is_read ? ST_ADDRR_ACK : ST_ADDRW_ACK;
            else if (is_read)
                code = (k == steps + 1) ? ST_RX_NACK : ST_RX_ACK;
            else
                code = ST_TX_ACK;
            // skip the tail of a zero-length transfer, there is nothing to move
            if (n == 0 && k > 1)
                return;
            send_status(code);
        end
    endtask

    // Mostly well-formed transfers, some raw items of any kind and field value
    task automatic run_random(input int unsigned goal);
        while (items_sent < goal)
        begin
            if ($urandom_range(99) < 85)
                run_transfer();
            else
                repeat ($urandom_range(1, 3))
                    push_item(3'($urandom_range(7)), $urandom, 4'($urandom_range(15)),
                              $urandom, $urandom, 1'b0, '0);
        end
    endtask

    task automatic add_row(input logic [2:0] m, input logic [15:0] len, input logic [3:0] st,
                           input logic [7:0] txb, input logic [7:0] rxb, input bit typed,
                           input result_t want);
        stim_row_t row;
        row.m     = m;
        row.len   = len;
        row.st    = st;
        row.txb   = txb;
        row.rxb   = rxb;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    initial
    begin : main
        int unsigned i;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        mode            = MODE_WRITE;
        transfer_length = '0;
        status_code     = ST_START;
        tx_byte         = '0;
        rx_data         = '0;
        out_stall       = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = ADDR_TARGET;
        pwdata          = '0;

        // Directed table; reset registers, so the address word is just the read bit.
        // Ignored kind and zero-length start leave everything at zero.
        add_row(MODE_IGNORED, 16'd0, ST_START, 8'h00, 8'h00, 1'b1,
                outcome(0, 0, START_LEAVE, 0, ACK_LEAVE, 0, 0, 0, 0, LINK_IDLE, TMO_LEAVE));
        add_row(MODE_WRITE, 16'd0, ST_START, 8'hFF, 8'hFF, 1'b1,
                outcome(0, 0, START_LEAVE, 0, ACK_LEAVE, 0, 0, 0, 0, LINK_IDLE, TMO_LEAVE));
        // Timeout from idle: error phase, done, disarm
        add_row(MODE_TMO, 16'hFFFF, ST_UNDEFINED, 8'h00, 8'h00, 1'b1,
                outcome(0, 0, START_LEAVE, 0, ACK_LEAVE, 0, 0, 0, 1, LINK_ERROR, TMO_DISARM));
        // Status past the defined range acts as "other"
        add_row(MODE_STATUS, 16'd0, ST_UNDEFINED, 8'h00, 8'h00, 1'b1,
                outcome(0, 0, START_LEAVE, 0, ACK_LEAVE, 1, 0, 0, 0, LINK_ERROR, TMO_DISARM));
        add_row(MODE_STATUS, 16'd0, ST_RELEASED, 8'h00, 8'h00, 1'b1,
                outcome(0, 0, START_LEAVE, 0, ACK_LEAVE, 0, 0, 0, 0, LINK_ERROR, TMO_DISARM));
        // Start and txAck outside their phases
        add_row(MODE_STATUS, 16'd0, ST_START, 8'h00, 8'h00, 1'b1,
                outcome(0, 0, START_WITHDRAW, 0, ACK_LEAVE, 1, 0, 0, 0, LINK_ERROR,
                        TMO_DISARM));
        add_row(MODE_STATUS, 16'd0, ST_TX_ACK, 8'h00, 8'h00, 1'b1,
                outcome(0, 0, START_LEAVE, 0, ACK_LEAVE, 1, 0, 0, 0, LINK_ERROR, TMO_DISARM));
        // Longest read, right after a txAck status
        add_row(MODE_READ, 16'hFFFF, ST_START, 8'h00, 8'h00, 1'b1,
                outcome(0, 0, START_REQUEST, 0, ACK_LEAVE, 1, 0, 0, 0, LINK_BUSY, TMO_ARM));
        add_row(MODE_STATUS, 16'd0, ST_RESTART, 8'h00, 8'h00, 1'b1,
                outcome(1, 11'd1, START_WITHDRAW, 0, ACK_LEAVE, 1, 0, 0, 0, LINK_BUSY,
                        TMO_LEAVE));
        add_row(MODE_STATUS, 16'd0, ST_ADDRR_ACK, 8'h00, 8'h00, 1'b1,
                outcome(0, 0, START_LEAVE, 0, ACK_ACK, 1, 0, 0, 0, LINK_BUSY, TMO_LEAVE));
        add_row(MODE_STATUS, 16'd0, ST_RX_ACK, 8'h00, 8'hFF, 1'b1,
                outcome(0, 0, START_LEAVE, 0, ACK_ACK, 1, 1, 8'hFF, 0, LINK_BUSY, TMO_LEAVE));
        add_row(MODE_STATUS, 16'd0, ST_RX_NACK, 8'h00, 8'h00, 1'b1,
                outcome(0, 0, START_LEAVE, 1, ACK_LEAVE, 1, 1, 8'h00, 1, LINK_IDLE,
                        TMO_DISARM));
        // rxNack again, now outside receive
        add_row(MODE_STATUS, 16'd0, ST_RX_NACK, 8'h00, 8'h00, 1'b1,
                outcome(0, 0, START_LEAVE, 0, ACK_LEAVE, 1, 0, 0, 0, LINK_IDLE, TMO_DISARM));
        // One-byte write ending in a repeated start, then a short read
        add_row(MODE_REPEAT, 16'd0, ST_START, 8'h00, 8'h00, 1'b0, '0);
        add_row(MODE_WRITE, 16'd1, ST_START, 8'h00, 8'h00, 1'b0, '0);
        add_row(MODE_STATUS, 16'd0, ST_START, 8'h00, 8'h00, 1'b0, '0);
        add_row(MODE_STATUS, 16'd0, ST_ADDRW_ACK, 8'hFF, 8'h00, 1'b0, '0);
        add_row(MODE_STATUS, 16'd0, ST_TX_ACK, 8'h00, 8'h00, 1'b0, '0);
        add_row(MODE_READ, 16'd2, ST_START, 8'h00, 8'h00, 1'b0, '0);
        add_row(MODE_STATUS, 16'd0, ST_RESTART, 8'h00, 8'h00, 1'b0, '0);
        add_row(MODE_STATUS, 16'd0, ST_ADDRR_ACK, 8'h00, 8'h00, 1'b0, '0);
        add_row(MODE_STATUS, 16'd0, ST_RX_ACK, 8'h00, 8'h5A, 1'b0, '0);
        add_row(MODE_STATUS, 16'd0, ST_RX_NACK, 8'h00, 8'hA5, 1'b0, '0);
        // rxAck with nothing left to receive: count holds at zero
        add_row(MODE_STATUS, 16'd0, ST_RX_ACK, 8'h00, 8'h3C, 1'b0, '0);
        add_row(MODE_STATUS, 16'd0, ST_ARB_LOST, 8'h00, 8'h00, 1'b1,
                outcome(0, 0, START_LEAVE, 1, ACK_LEAVE, 1, 0, 0, 1, LINK_ERROR, TMO_DISARM));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < directed_rows.size(); i++)
            push_item(directed_rows[i].m, directed_rows[i].len, directed_rows[i].st,
                      directed_rows[i].txb, directed_rows[i].rxb, directed_rows[i].typed,
                      directed_rows[i].want);
        settle();

        // Phase A: widest address, slow receiver
        write_register(ADDR_TARGET, 32'h3FF);
        write_register(ADDR_TEN, 32'h1);
        run_random(200);
        settle();

        // Phase B: random address, slow sender
        send_idle_pct = 81;
        stall_pct     = 31;
        write_register(ADDR_TARGET, $urandom_range(1, 1022));
        write_register(ADDR_TEN, 32'h0);
        run_random(400);
        settle();

        // Phase C: address zero, full rate both sides
        send_idle_pct = 0;
        stall_pct     = 0;
        write_register(ADDR_TARGET, 32'h0);
        write_register(ADDR_TEN, 32'h1);
        run_random(600);
        settle();

        $display("Covered %0d items, %0d results compared, %0d register writes,",
                 items_sent, results_checked, reg_writes);
        $display("under three sender/receiver pressure settings; %0d mismatches.",
                 mismatch_count);
        if (mismatch_count == 0)
            $display("i2c_master_byte_sequencer regression: pass");
        else
            $display("i2c_master_byte_sequencer regression: fail");
        $finish;
    end

endmodule
